[rtl/core/ppc_pkg.sv]
// Shared package for the polygon plane clipper.
// Holds widths, limits, register indexes, the sequencer state type and saturation helpers.
// No dependencies.
`timescale 1ns / 1ps

package ppc_pkg;

  localparam int MAX_VERTS = 16;
  localparam int ADDR_W    = $clog2(MAX_VERTS);
  localparam int CNT_W     = $clog2(MAX_VERTS + 1);
  localparam int OUT_CAP   = 24;
  localparam int NOUT_W    = $clog2(OUT_CAP + 1);
  localparam int COORD_W   = 32;
  localparam int VTX_W     = 3 * COORD_W;
  localparam int DIST_W    = 48;
  localparam int FRAC_W    = 17;
  localparam int REM_W     = 50;
  localparam int PROD_W    = 66;
  localparam int ACC_W     = 68;
  localparam int STEP_W    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int AXES      = 3;

  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(AXES);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(FRAC_W - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Z = 3'd5;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_READ   = 11'b000_0000_0010,
    S_LATCH  = 11'b000_0000_0100,
    S_DIST   = 11'b000_0000_1000,
    S_DECIDE = 11'b000_0001_0000,
    S_DIV    = 11'b000_0010_0000,
    S_INTERP = 11'b000_0100_0000,
    S_EMIT_P = 11'b000_1000_0000,
    S_EMIT_E = 11'b001_0000_0000,
    S_NEXT   = 11'b010_0000_0000,
    S_FLUSH  = 11'b100_0000_0000
  } state_t;

  // Clamp a 52-bit distance to 48-bit signed
  function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [51:0] v);
    logic hi_same;
    logic lo_same;
    hi_same = &v[51:DIST_W-1];
    lo_same = ~|v[51:DIST_W-1];
    if (hi_same || lo_same) begin
      sat_dist = v[DIST_W-1:0];
    end else if (v[51]) begin
      sat_dist = {1'b1, {(DIST_W-1){1'b0}}};
    end else begin
      sat_dist = {1'b0, {(DIST_W-1){1'b1}}};
    end
  endfunction

  // Clamp a 36-bit coordinate to 32-bit signed
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [35:0] v);
    logic hi_same;
    logic lo_same;
    hi_same = &v[35:COORD_W-1];
    lo_same = ~|v[35:COORD_W-1];
    if (hi_same || lo_same) begin
      sat_coord = v[COORD_W-1:0];
    end else if (v[35]) begin
      sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

[rtl/core/ppc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module ppc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/polygon_plane_clip_unit.sv]
// Single-plane polygon clipper: top level with sequencer and shared multiply/divide datapath.
// Depends on ppc_pkg and ppc_ram.
`timescale 1ns / 1ps

// Usage:
//  Vertex channel (in_valid/in_stall, vert_*): one transaction per vertex of a
//  closed polygon; vert_last marks the final vertex and starts clipping. Up to
//  16 vertices are stored, later ones are dropped. A non-last vertex does not
//  stall. After the last vertex in_stall stays high while the polygon is walked.
//  Result channel (out_valid/out_stall, out_*): the clipped polygon, at most 24
//  points, out_last on the final one. If nothing survives, one transaction with
//  out_empty and out_last high and zero coordinates is given.
//  Timing: the single shared 33x33 multiplier and the 17-step restoring divider
//  set the pace. Each edge computes the distance of its end vertex, then, when
//  it crosses the plane, divides and interpolates the crossing point, then
//  emits its points.
//  A stalled output holds its point; the sequencer waits when a further point
//  is ready and the output register is still occupied.
//  Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//  write it only while idle. Indexes 6 and 7 are ignored.
//  Reset (rst, synchronous): plane normal returns to +z, anchor to origin, the
//  vertex count clears, the output is empty. The store itself is not cleared.
module polygon_plane_clip_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ppc_pkg::COORD_W-1:0]  vert_x,
  input  logic signed [ppc_pkg::COORD_W-1:0]  vert_y,
  input  logic signed [ppc_pkg::COORD_W-1:0]  vert_z,
  input  logic                                vert_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ppc_pkg::COORD_W-1:0]  out_x,
  output logic signed [ppc_pkg::COORD_W-1:0]  out_y,
  output logic signed [ppc_pkg::COORD_W-1:0]  out_z,
  output logic                                out_last,
  output logic                                out_empty,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppc_pkg::COORD_W-1:0]         cfg_data
);

  import ppc_pkg::*;

  state_t state;

  logic signed [COORD_W-1:0] normal [AXES];
  logic signed [COORD_W-1:0] anchor [AXES];
  logic signed [COORD_W-1:0] ev     [AXES];
  logic signed [COORD_W-1:0] sv     [AXES];
  logic signed [COORD_W-1:0] pt     [AXES];
  logic signed [COORD_W-1:0] pend   [AXES];
  logic signed [COORD_W-1:0] cand   [AXES];

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          eidx;
  logic [ADDR_W-1:0]         rd_addr;
  logic [STEP_W-1:0]         step;
  logic                      first;
  logic                      emit_e;
  logic                      from_s;
  logic                      pend_valid;
  logic [NOUT_W-1:0]         n;
  logic signed [DIST_W-1:0]  ds;
  logic signed [DIST_W-1:0]  de;
  logic signed [DIST_W-1:0]  dnew;
  logic [REM_W-1:0]          rem;
  logic [REM_W-1:0]          den;
  logic [FRAC_W-1:0]         q;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic                      in_acc;
  logic                      out_free;
  logic                      store_ok;
  logic [CNT_W-1:0]          count_next;
  logic [1:0]                ax;
  logic [1:0]                wr_ax;
  logic signed [32:0]        ma;
  logic signed [32:0]        mb;
  logic signed [PROD_W-1:0]  mprod;
  logic signed [COORD_W-1:0] o_k;
  logic signed [COORD_W-1:0] i_k;
  logic signed [35:0]        isum;
  logic [VTX_W-1:0]          rdata;
  logic [CNT_W-1:0]          eidx_next;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign store_ok  = (count < CNT_W'(MAX_VERTS));
  assign count_next = store_ok ? count + 1'b1 : count;
  assign eidx_next = eidx + 1'b1;

  // Vertex store
  ppc_ram #(
    .WIDTH(VTX_W),
    .DEPTH(MAX_VERTS)
  ) u_store (
    .clk  (clk),
    .we   (in_acc && store_ok),
    .waddr(count[ADDR_W-1:0]),
    .wdata({vert_z, vert_y, vert_x}),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // Select axis operands for the shared multiplier
  always_comb begin
    ax    = (step[1:0] == 2'd3) ? 2'd2 : step[1:0];
    wr_ax = (step[1:0] == 2'd0) ? 2'd0 : step[1:0] - 2'd1;
    if (state == S_INTERP) begin
      o_k = from_s ? sv[ax] : ev[ax];
      i_k = from_s ? ev[ax] : sv[ax];
      ma  = {i_k[COORD_W-1], i_k} - {o_k[COORD_W-1], o_k};
      mb  = {16'd0, q};
    end else begin
      o_k = '0;
      i_k = '0;
      ma  = {ev[ax][COORD_W-1], ev[ax]} - {anchor[ax][COORD_W-1], anchor[ax]};
      mb  = {normal[ax][COORD_W-1], normal[ax]};
    end
    mprod = ma * mb;
  end

  // Finish distance and interpolated coordinate
  always_comb begin
    logic signed [COORD_W-1:0] o_w;
    o_w  = from_s ? sv[wr_ax] : ev[wr_ax];
    dnew = sat_dist(acc[ACC_W-1:16]);
    isum = {{4{o_w[COORD_W-1]}}, o_w} + prod[51:16];
  end

  // Point offered to the pending register
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      cand[k] = (state == S_EMIT_P) ? pt[k] : ev[k];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      normal[0] <= '0;
      normal[1] <= '0;
      normal[2] <= 32'sd65536;
      anchor[0] <= '0;
      anchor[1] <= '0;
      anchor[2] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NORMAL_X: normal[0] <= cfg_data;
        REG_NORMAL_Y: normal[1] <= cfg_data;
        REG_NORMAL_Z: normal[2] <= cfg_data;
        REG_ANCHOR_X: anchor[0] <= cfg_data;
        REG_ANCHOR_Y: anchor[1] <= cfg_data;
        REG_ANCHOR_Z: anchor[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register: drop on take, load on push
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (((state == S_EMIT_P) || (state == S_EMIT_E)) && (n != NOUT_W'(OUT_CAP))
                 && pend_valid && out_free) begin
      out_valid <= 1'b1;
    end else if ((state == S_FLUSH) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (((state == S_EMIT_P) || (state == S_EMIT_E)) && (n != NOUT_W'(OUT_CAP))
        && pend_valid && out_free) begin
      out_x     <= pend[0];
      out_y     <= pend[1];
      out_z     <= pend[2];
      out_last  <= 1'b0;
      out_empty <= 1'b0;
    end else if ((state == S_FLUSH) && out_free) begin
      out_x     <= pend_valid ? pend[0] : '0;
      out_y     <= pend_valid ? pend[1] : '0;
      out_z     <= pend_valid ? pend[2] : '0;
      out_last  <= 1'b1;
      out_empty <= !pend_valid;
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      n          <= '0;
      first      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (vert_last) begin
              count <= '0;
              first <= 1'b1;
              state <= S_READ;
            end else begin
              count <= count_next;
            end
          end
        end
        S_READ:  state <= S_LATCH;
        S_LATCH: state <= S_DIST;
        S_DIST: begin
          if (step == MUL_LAST) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (first) begin
            first <= 1'b0;
            state <= S_READ;
          end else if ((ds > 0) != (dnew > 0)) begin
            state <= S_DIV;
          end else if (ds > 0) begin
            state <= S_NEXT;
          end else begin
            state <= S_EMIT_E;
          end
        end
        S_DIV: begin
          if (step == DIV_LAST) begin
            state <= S_INTERP;
          end
        end
        S_INTERP: begin
          if (step == MUL_LAST) begin
            state <= S_EMIT_P;
          end
        end
        S_EMIT_P, S_EMIT_E: begin
          if ((n == NOUT_W'(OUT_CAP)) || !pend_valid || out_free) begin
            if (n != NOUT_W'(OUT_CAP)) begin
              pend_valid <= 1'b1;
              n          <= n + 1'b1;
            end
            state <= ((state == S_EMIT_P) && emit_e) ? S_EMIT_E : S_NEXT;
          end
        end
        S_NEXT: begin
          state <= (eidx_next == cnt) ? S_FLUSH : S_READ;
        end
        S_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            n          <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cnt     <= count_next;
        rd_addr <= ADDR_W'(count_next - 1'b1);
        eidx    <= '0;
      end
      S_LATCH: begin
        ev[0] <= rdata[COORD_W-1:0];
        ev[1] <= rdata[2*COORD_W-1:COORD_W];
        ev[2] <= rdata[VTX_W-1:2*COORD_W];
        step  <= '0;
        acc   <= '0;
      end
      S_DIST: begin
        if (step != MUL_LAST) begin
          prod <= mprod;
        end
        if (step != '0) begin
          acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
        end
        step <= step + 1'b1;
      end
      S_DECIDE: begin
        step <= '0;
        q    <= '0;
        if (first) begin
          sv      <= ev;
          ds      <= dnew;
          rd_addr <= '0;
        end else begin
          de <= dnew;
          if (ds > 0) begin
            from_s <= 1'b1;
            emit_e <= 1'b1;
            rem    <= {{(REM_W-DIST_W){1'b0}}, ds};
            den    <= {{2{ds[DIST_W-1]}}, ds} - {{2{dnew[DIST_W-1]}}, dnew};
          end else begin
            from_s <= 1'b0;
            emit_e <= 1'b0;
            rem    <= {{(REM_W-DIST_W){1'b0}}, dnew};
            den    <= {{2{dnew[DIST_W-1]}}, dnew} - {{2{ds[DIST_W-1]}}, ds};
          end
        end
      end
      S_DIV: begin
        // One quotient bit per cycle, restoring
        if (rem >= den) begin
          rem <= {rem[REM_W-2:0] - den[REM_W-2:0], 1'b0};
          q   <= {q[FRAC_W-2:0], 1'b1};
        end else begin
          rem <= {rem[REM_W-2:0], 1'b0};
          q   <= {q[FRAC_W-2:0], 1'b0};
        end
        step <= (step == DIV_LAST) ? '0 : step + 1'b1;
      end
      S_INTERP: begin
        if (step != MUL_LAST) begin
          prod <= mprod;
        end
        if (step != '0) begin
          pt[wr_ax] <= sat_coord(isum);
        end
        step <= step + 1'b1;
      end
      S_EMIT_P, S_EMIT_E: begin
        if ((n != NOUT_W'(OUT_CAP)) && (!pend_valid || out_free)) begin
          pend <= cand;
        end
      end
      S_NEXT: begin
        sv      <= ev;
        ds      <= de;
        eidx    <= eidx_next;
        rd_addr <= ADDR_W'(eidx_next);
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_last)
    else $error("empty result without last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> (out_x == 0) && (out_y == 0) && (out_z == 0))
    else $error("empty result with non-zero coordinates");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERTS))
    else $error("vertex count beyond store depth");

  a_cap_bound: assert property (@(posedge clk) disable iff (rst)
    n <= NOUT_W'(OUT_CAP))
    else $error("result count beyond cap");

  a_pend_when_counted: assert property (@(posedge clk) disable iff (rst)
    (n != '0) |-> pend_valid)
    else $error("results counted but none pending");
`endif

endmodule
